### sv/lqrvt_pkg.sv
// shared types, constants and tables for the lqr vector thrust controller
package lqrvt_pkg;

	localparam int STATE_COUNT       = 12;
	localparam int CORDIC_STEPS_DEF  = 16;
	localparam int MID_DEPTH_DEF     = 4;
	localparam int OUT_DEPTH_DEF     = 4;

	// datapath widths
	localparam int PW   = 42;   // state times gain
	localparam int FW   = 35;   // forcing product
	localparam int AW   = 48;   // group sums
	localparam int NW   = 62;   // scaled numerator
	localparam int MW   = 60;   // biased dividend
	localparam int NDIV = 41;   // quotient bits
	localparam int RW   = MW - NDIV; // remainder bits
	localparam int UW   = NDIV; // control effort
	localparam int XW   = 44;   // cordic vector
	localparam int ZW   = 34;   // cordic angle, q30

	// long division by 5^8 in quotient digits
	localparam int DSTG     = 4;                          // digits
	localparam int DGW      = 13;                         // bits per digit
	localparam int DLW      = NDIV - (DSTG - 1) * DGW;    // bits of the last digit
	localparam int RECIP_SH = 51;

	localparam logic [RW-1:0]        DIV_D      = RW'(390625);
	localparam logic [32:0]          DIV_RECIP  = 33'd5764607524; // ceil(2^51 / 5^8)
	localparam logic signed [NW-1:0] ROUND_HALF = 62'sd195312;
	localparam logic signed [NW-1:0] DIV_BIAS   = 62'sd429496729600000000;
	localparam logic signed [ZW-1:0] HALF_PI    = 34'sd1686629713;
	localparam logic signed [16:0]  ANG_LIM    = 17'sd25736;
	localparam logic signed [60:0]  MAG_GAIN   = 61'sd39797;

	localparam logic signed [17:0] GAIN_E4 [4][STATE_COUNT] = '{
		'{18'sd0, -18'sd2236, -18'sd2236, 18'sd0, -18'sd8510, -18'sd7345,
		  -18'sd49191, 18'sd0, 18'sd0, -18'sd14197, 18'sd0, 18'sd0},
		'{-18'sd2235, 18'sd0, 18'sd0, -18'sd8507, 18'sd0, 18'sd0,
		  18'sd0, 18'sd49187, 18'sd7074, 18'sd0, 18'sd14197, 18'sd14157},
		'{18'sd0, 18'sd2236, -18'sd2236, 18'sd0, 18'sd8510, -18'sd7345,
		  18'sd49191, 18'sd0, 18'sd0, 18'sd14197, 18'sd0, 18'sd0},
		'{-18'sd2237, 18'sd0, 18'sd0, -18'sd8513, 18'sd0, 18'sd0,
		  18'sd0, 18'sd49186, -18'sd7068, 18'sd0, 18'sd14197, -18'sd14140}
	};

	localparam logic signed [17:0] FORCE_E8 [4] = '{18'sd0, 18'sd3285, 18'sd0, 18'sd775};

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] vel_z;
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        thrust_r;
		logic signed [15:0] angle_r;
		logic [15:0]        thrust_l;
		logic signed [15:0] angle_l;
	} out_item_t;

	// one pre-rotated vector ready for cordic
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} side_t;

	typedef struct packed {
		side_t right;
		side_t left;
	} mid_item_t;

	// arctangent of 2^-i in q30 radians
	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0: v = 34'sd843314857;
			1: v = 34'sd497837830;
			2: v = 34'sd263043837;
			3: v = 34'sd133525159;
			4: v = 34'sd67021687;
			5: v = 34'sd33543516;
			6: v = 34'sd16775851;
			7: v = 34'sd8388437;
			8: v = 34'sd4194283;
			9: v = 34'sd2097149;
			default: begin
				if (i > 30) v = '0;
				else v = 34'sd1 <<< (30 - i);
			end
		endcase
		return v;
	endfunction

endpackage

### sv/lqr_gain_to_vector_thrust.sv
// top level of the lqr state feedback controller with vectored thrust outputs
// One vehicle state goes in per transaction and one right/left thrust pair comes
// out, in order. A new transaction is taken every cycle while the result side keeps
// popping. Each passes the front pipeline (gain products, group sums, numerator
// scaling, a long division by 5^8 as four quotient digits of two stages each,
// classification), the middle queue, then the back pipeline (one cordic iteration
// per stage, 16 steps by default, plus the magnitude multiply) before the result
// queue. When the result queue fills the back pipeline freezes, and once the
// middle queue fills the front pipeline freezes and full is raised. pitch_offset
// should only be written while no transaction is in flight.
module lqr_gain_to_vector_thrust #(
	parameter int CORDIC_STEPS = lqrvt_pkg::CORDIC_STEPS_DEF,
	parameter int MID_DEPTH    = lqrvt_pkg::MID_DEPTH_DEF,
	parameter int OUT_DEPTH    = lqrvt_pkg::OUT_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic signed [15:0]   cfg_wdata,
	input  logic                 push,
	output logic                 full,
	input  lqrvt_pkg::in_item_t  in_data,
	output logic                 empty,
	input  logic                 pop,
	output lqrvt_pkg::out_item_t out_data
);
	import lqrvt_pkg::*;

	logic signed [15:0] pitch_offset_q;
	logic               mid_full, mid_empty, mid_push, mid_pop;
	mid_item_t          mid_wdata, mid_rdata;
	logic               out_full, out_push;
	out_item_t          out_wdata;

	// the single configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pitch_offset_q <= '0;
		else if (cfg_wen) pitch_offset_q <= cfg_wdata;
	end

	// input side stalls as a whole when the middle queue is full
	assign full = mid_full;

	lqrvt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (push && !full),
		.in_data      (in_data),
		.pitch_offset (pitch_offset_q),
		.mid_full     (mid_full),
		.mid_push     (mid_push),
		.mid_data     (mid_wdata)
	);

	// decouples the divider pipeline from the cordic pipeline
	lqrvt_fifo #(
		.DEPTH (MID_DEPTH),
		.W     ($bits(mid_item_t))
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.full   (mid_full),
		.empty  (mid_empty)
	);

	lqrvt_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_data  (mid_rdata),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_data  (out_wdata)
	);

	// result queue seen by the consumer
	lqrvt_fifo #(
		.DEPTH (OUT_DEPTH),
		.W     ($bits(out_item_t))
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_wdata),
		.pop    (pop),
		.rdata  (out_data),
		.full   (out_full),
		.empty  (empty)
	);
endmodule

### sv/lqrvt_fifo.sv
// small register queue used between and after the pipelines
module lqrvt_fifo #(
	parameter int DEPTH = 4,
	parameter int W     = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);
	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    mem_q [DEPTH];
	logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] cnt_q;
	logic            do_push, do_pop;

	assign full    = (cnt_q == CNTW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				if (wr_ptr_q == PTRW'(DEPTH - 1)) wr_ptr_q <= '0;
				else wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				if (rd_ptr_q == PTRW'(DEPTH - 1)) rd_ptr_q <= '0;
				else rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

### sv/lqrvt_front.sv
// front pipeline: gain product, exact rounding division, vector classification
module lqrvt_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  lqrvt_pkg::in_item_t   in_data,
	input  logic signed [15:0]    pitch_offset,
	input  logic                  mid_full,
	output logic                  mid_push,
	output lqrvt_pkg::mid_item_t  mid_data
);
	import lqrvt_pkg::*;

	function automatic side_t classify(input logic signed [UW-1:0] ux,
	                                   input logic signed [UW-1:0] uy);
		side_t s;
		s.zero = (ux == '0) && (uy == '0);
		if (ux[UW-1]) begin
			if (!uy[UW-1]) begin
				s.x = XW'(uy);
				s.y = -XW'(ux);
				s.z = HALF_PI;
			end else begin
				s.x = -XW'(uy);
				s.y = XW'(ux);
				s.z = -HALF_PI;
			end
		end else begin
			s.x = XW'(ux);
			s.y = XW'(uy);
			s.z = '0;
		end
		return s;
	endfunction

	logic                   en;
	logic signed [23:0]     st [STATE_COUNT];
	logic signed [16:0]     pofs;
	logic signed [PW-1:0]   prod_s1 [4][STATE_COUNT];
	logic signed [FW-1:0]   frc_s1 [4];
	logic                   vld_s1;
	logic signed [AW-1:0]   pv_sum [4], ang_sum [4], rate_sum [4];
	logic signed [AW-1:0]   pv_s2 [4], ang_s2 [4], rate_s2 [4];
	logic signed [FW-1:0]   frc_s2 [4];
	logic                   vld_s2;
	logic signed [NW-1:0]   mnum [4];
	logic [RW-1:0]          div_rem_s [DSTG][4];
	logic [NDIV-1:0]        div_word_s [DSTG+1][4];
	logic                   vld_div_s [2*DSTG+1];
	logic signed [UW-1:0]   u [4];
	mid_item_t              item_sn;
	logic                   vld_sn;

	assign en = !mid_full;

	always_comb begin
		st[0]  = in_data.pos_x;
		st[1]  = in_data.pos_y;
		st[2]  = in_data.pos_z;
		st[3]  = 24'(in_data.vel_x);
		st[4]  = 24'(in_data.vel_y);
		st[5]  = 24'(in_data.vel_z);
		st[6]  = 24'(in_data.roll);
		st[7]  = 24'(in_data.pitch);
		st[8]  = 24'(in_data.yaw);
		st[9]  = 24'(in_data.rate_x);
		st[10] = 24'(in_data.rate_y);
		st[11] = 24'(in_data.rate_z);
		pofs   = 17'(in_data.pitch) + 17'(pitch_offset);
	end

	// stage 1: one constant product per state element and row
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				for (int j = 0; j < STATE_COUNT; j++)
					prod_s1[r][j] <= PW'(st[j]) * PW'(GAIN_E4[r][j]);
				frc_s1[r] <= FW'(pofs) * FW'(FORCE_E8[r]);
			end
		end
	end

	// stage 2: sums per unit group
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			pv_sum[r]   = '0;
			ang_sum[r]  = '0;
			rate_sum[r] = '0;
			for (int j = 0; j < 6; j++) pv_sum[r] = pv_sum[r] + AW'(prod_s1[r][j]);
			for (int j = 6; j < 9; j++) ang_sum[r] = ang_sum[r] + AW'(prod_s1[r][j]);
			for (int j = 9; j < 12; j++) rate_sum[r] = rate_sum[r] + AW'(prod_s1[r][j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				pv_s2[r]   <= pv_sum[r];
				ang_s2[r]  <= ang_sum[r];
				rate_s2[r] <= rate_sum[r];
				frc_s2[r]  <= frc_s1[r];
			end
		end
	end

	// stage 3: eight times the numerator, rounding half and a bias that keeps it positive
	always_comb begin
		for (int r = 0; r < 4; r++)
			mnum[r] = NW'(pv_s2[r]) * 62'sd6553600 + NW'(ang_s2[r]) * 62'sd80000
			        + NW'(rate_s2[r]) * 62'sd640000 - NW'(frc_s2[r]) * 62'sd8
			        + ROUND_HALF + DIV_BIAS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				div_rem_s[0][r]  <= mnum[r][MW-1:NDIV];
				div_word_s[0][r] <= mnum[r][NDIV-1:0];
			end
		end
	end

	// long division by 5^8, one quotient digit per two stages: the digit comes from
	// a reciprocal product, exact because the partial dividend stays below 2^32,
	// then the remainder is formed for the next digit
	for (genvar k = 0; k < DSTG; k++) begin : g_div
		localparam int DW = (k < DSTG - 1) ? DGW : DLW;
		logic [31:0]     dvd [4];
		logic [64:0]     qprod [4];
		logic [NDIV-1:0] word_sa [4];
		always_comb begin
			for (int r = 0; r < 4; r++) begin
				dvd[r]   = 32'({div_rem_s[k][r], div_word_s[k][r][NDIV-1 -: DW]});
				qprod[r] = 65'(dvd[r]) * 65'(DIV_RECIP);
			end
		end
		// dividend bits shift out at the top, quotient bits shift in at the bottom
		always_ff @(posedge clk) begin
			if (en) begin
				for (int r = 0; r < 4; r++)
					word_sa[r] <= {div_word_s[k][r][NDIV-DW-1:0], qprod[r][RECIP_SH +: DW]};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int r = 0; r < 4; r++) div_word_s[k+1][r] <= word_sa[r];
			end
		end
		if (k < DSTG - 1) begin : g_rem
			logic [31:0]    dvd_sa [4];
			logic [DGW-1:0] qd_sa [4];
			always_ff @(posedge clk) begin
				if (en) begin
					for (int r = 0; r < 4; r++) begin
						dvd_sa[r] <= dvd[r];
						qd_sa[r]  <= qprod[r][RECIP_SH +: DGW];
					end
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					for (int r = 0; r < 4; r++)
						div_rem_s[k+1][r] <= RW'(dvd_sa[r] - 32'(qd_sa[r]) * 32'(DIV_D));
				end
			end
		end
	end

	// removing the bias is a flip of the quotient msb
	always_comb begin
		for (int r = 0; r < 4; r++)
			u[r] = {~div_word_s[DSTG][r][NDIV-1], div_word_s[DSTG][r][NDIV-2:0]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_sn.right <= classify(u[0], u[1]);
			item_sn.left  <= classify(u[2], u[3]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_sn <= 1'b0;
			for (int k = 0; k <= 2 * DSTG; k++) vld_div_s[k] <= 1'b0;
		end else if (en) begin
			vld_s1       <= in_valid;
			vld_s2       <= vld_s1;
			vld_div_s[0] <= vld_s2;
			for (int k = 1; k <= 2 * DSTG; k++) vld_div_s[k] <= vld_div_s[k-1];
			vld_sn       <= vld_div_s[2*DSTG];
		end
	end

	assign mid_push = en && vld_sn;
	assign mid_data = item_sn;
endmodule

### sv/lqrvt_back.sv
// back pipeline: vectoring cordic, magnitude scaling and angle rounding
module lqrvt_back #(
	parameter int CORDIC_STEPS = lqrvt_pkg::CORDIC_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  mid_empty,
	input  lqrvt_pkg::mid_item_t  mid_data,
	output logic                  mid_pop,
	input  logic                  out_full,
	output logic                  out_push,
	output lqrvt_pkg::out_item_t  out_data
);
	import lqrvt_pkg::*;

	logic                  en;
	side_t                 cs_in [CORDIC_STEPS][2];
	logic                  vin [CORDIC_STEPS];
	side_t                 cs_s [CORDIC_STEPS][2];
	logic                  vld_s [CORDIC_STEPS];
	logic signed [60:0]    prod_sp [2];
	logic signed [15:0]    ang_sp [2];
	logic                  zero_sp [2];
	logic                  vld_sp;
	logic signed [ZW-1:0]  zsum [2];
	logic signed [16:0]    arnd [2];
	logic signed [15:0]    aclp [2];
	logic signed [60:0]    rsum [2];
	logic [15:0]           mag [2];

	assign en      = !out_full;
	assign mid_pop = en && !mid_empty;

	assign cs_in[0][0] = mid_data.right;
	assign cs_in[0][1] = mid_data.left;
	assign vin[0]      = !mid_empty;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [ZW-1:0] ATAN = atan_q30(i);
		side_t nx [2];
		if (i > 0) begin : g_link
			assign cs_in[i][0] = cs_s[i-1][0];
			assign cs_in[i][1] = cs_s[i-1][1];
			assign vin[i]      = vld_s[i-1];
		end
		always_comb begin
			for (int k = 0; k < 2; k++) begin
				nx[k].zero = cs_in[i][k].zero;
				if (!cs_in[i][k].y[XW-1]) begin
					nx[k].x = cs_in[i][k].x + (cs_in[i][k].y >>> i);
					nx[k].y = cs_in[i][k].y - (cs_in[i][k].x >>> i);
					nx[k].z = cs_in[i][k].z + ATAN;
				end else begin
					nx[k].x = cs_in[i][k].x - (cs_in[i][k].y >>> i);
					nx[k].y = cs_in[i][k].y + (cs_in[i][k].x >>> i);
					nx[k].z = cs_in[i][k].z - ATAN;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				cs_s[i][0] <= nx[0];
				cs_s[i][1] <= nx[1];
			end
		end
	end

	// angle rounded half up to q13 and clamped
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			zsum[k] = cs_s[CORDIC_STEPS-1][k].z + 34'sd65536;
			arnd[k] = zsum[k][ZW-1:17];
			if (arnd[k] > ANG_LIM) aclp[k] = 16'(ANG_LIM);
			else if (arnd[k] < -ANG_LIM) aclp[k] = 16'(-ANG_LIM);
			else aclp[k] = arnd[k][15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				prod_sp[k] <= 61'(cs_s[CORDIC_STEPS-1][k].x) * MAG_GAIN;
				ang_sp[k]  <= aclp[k];
				zero_sp[k] <= cs_s[CORDIC_STEPS-1][k].zero;
			end
		end
	end

	// gain compensation rounded half up, saturated at full scale
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			rsum[k] = prod_sp[k] + 61'sd2147483648;
			if (zero_sp[k]) mag[k] = '0;
			else if (|rsum[k][60:48]) mag[k] = 16'hFFFF;
			else mag[k] = rsum[k][47:32];
		end
		out_data.thrust_r = mag[0];
		out_data.angle_r  = zero_sp[0] ? 16'sd0 : ang_sp[0];
		out_data.thrust_l = mag[1];
		out_data.angle_l  = zero_sp[1] ? 16'sd0 : ang_sp[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CORDIC_STEPS; i++) vld_s[i] <= 1'b0;
			vld_sp <= 1'b0;
		end else if (en) begin
			for (int i = 0; i < CORDIC_STEPS; i++) vld_s[i] <= vin[i];
			vld_sp <= vld_s[CORDIC_STEPS-1];
		end
	end

	assign out_push = en && vld_sp;
endmodule
